// ----- src/slcr_pkg.sv -----
// Package for the SHiP/LRU replacement-state block.
// Types, sizes and constants used by the top level.
`default_nettype none
package slcr_pkg;
	localparam int SETS = 64;
	localparam int WAYS = 16;
	localparam int CNT_ENTRIES = 1024;
	localparam int SET_W = 6;
	localparam int WAY_W = 4;
	localparam int SIG_W = 10;
	localparam int CNT_W = 2;
	localparam int RRPV_W = 2;
	localparam int RANK_W = 4;
	localparam int LINE_W = RRPV_W + 1 + SIG_W + RANK_W;
	localparam int ROW_W = LINE_W * WAYS;
	localparam logic [RRPV_W-1:0] RRPV_MAX = 2'd3;
	localparam logic [RRPV_W-1:0] RRPV_LONG = 2'd2;
	localparam logic [CNT_W-1:0] CNT_MAX = 2'd3;
	localparam logic [CNT_W-1:0] CNT_INIT = 2'd1;
	localparam logic POLICY_LRU = 1'b0;
	localparam logic POLICY_SHIP = 1'b1;

	typedef struct packed {
		logic [RRPV_W-1:0] rrpv;
		logic reused;
		logic [SIG_W-1:0] sig;
		logic [RANK_W-1:0] rank;
	} line_t;
endpackage
`default_nettype wire

// ----- src/slcr_ram.sv -----
// Generic single-port-write, one-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module slcr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic clk,
	input  wire logic we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- src/ship_lru_cache_replacement.sv -----
// SHiP / true-LRU replacement state: one result beat per access beat.
// Each accepted beat passes through the read, counter and write states to its result.
// Flow: no new access is taken until the last one is written; a result held by the
// sink stalls the next access in its read state. Set row and counter RAM
// read-modify-write. Reset: a clearing pass over the set RAM and the counter RAM,
// run together; no beat accepted then.
`default_nettype none
module ship_lru_cache_replacement
	import slcr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic cfg_data,
	input  wire logic s_tvalid,
	output logic s_tready,
	// tdata: set_index[5:0], hit_way[9:6], pc[41:10], zero pad [47:42]
	input  wire logic [47:0] s_tdata,
	// tuser: hit
	input  wire logic s_tuser,
	output logic m_tvalid,
	input  wire logic m_tready,
	// tdata: way[3:0], evicted_signature[13:4], counter_lowered[14], pad [15]
	output logic [15:0] m_tdata,
	// tuser: replaced
	output logic m_tuser
);
	localparam int CLR_W = $clog2(CNT_ENTRIES) + 1;
	localparam logic [2:0] ST_CLR = 3'd0, ST_IDLE = 3'd1, ST_RD = 3'd2,
		ST_CNT = 3'd3, ST_WR = 3'd4;

	logic [2:0] st_q;
	logic [CLR_W-1:0] clr_q;
	logic policy_q;
	logic [SET_W-1:0] set_q;
	logic hit_q;
	logic [WAY_W-1:0] hw_q;
	logic [SIG_W-1:0] nsig_q;
	logic [WAY_W-1:0] vic_q;
	logic [SIG_W-1:0] esig_q;
	logic low_q;
	logic [CNT_W-1:0] ecnt_q;

	logic row_we, cnt_we;
	logic [SET_W-1:0] row_waddr, row_raddr;
	logic [ROW_W-1:0] row_wdata, row_rdata, wd;
	logic [SIG_W-1:0] cnt_waddr, cnt_raddr;
	logic [CNT_W-1:0] cnt_wdata, cnt_rdata;

	slcr_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_row (
		.clk(clk), .we(row_we), .waddr(row_waddr), .wdata(wd),
		.raddr(row_raddr), .rdata(row_rdata));
	slcr_ram #(.WIDTH(CNT_W), .DEPTH(CNT_ENTRIES)) u_cnt (
		.clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.raddr(cnt_raddr), .rdata(cnt_rdata));

	assign cfg_ready = 1'b1;
	assign s_tready = (st_q == ST_IDLE);
	wire accept = s_tvalid && s_tready;

	// row is read on the accepting edge and stays on the RAM output until the write
	assign row_raddr = accept ? s_tdata[5:0] : set_q;

	// row decode and victim search on the RAM output
	line_t ln [WAYS];
	logic [RRPV_W-1:0] maxr;
	logic [WAY_W-1:0] lru_vic, ship_vic;
	line_t aged [WAYS];
	always_comb begin
		maxr = '0;
		lru_vic = '0;
		ship_vic = '0;
		for (int i = 0; i < WAYS; i++) begin
			ln[i] = row_rdata[i*LINE_W +: LINE_W];
			if (ln[i].rrpv > maxr) maxr = ln[i].rrpv;
		end
		for (int i = WAYS-1; i >= 0; i--) begin
			aged[i] = ln[i];
			aged[i].rrpv = ln[i].rrpv + (RRPV_MAX - maxr);
			if (aged[i].rrpv == RRPV_MAX) ship_vic = WAY_W'(i);
			if (ln[i].rank == RANK_W'(WAYS-1)) lru_vic = WAY_W'(i);
		end
	end

	logic [WAY_W-1:0] vic_c;
	assign vic_c = !hit_q ? (policy_q == POLICY_SHIP ? ship_vic : lru_vic) : hw_q;

	// new signature's count is zero; the RAM returned the pre-decrement value
	// when it is also the evicted signature
	logic ins_zero;
	assign ins_zero = (esig_q == nsig_q && low_q) ? (ecnt_q <= CNT_W'(1))
		: (cnt_rdata == '0);

	// new row built in write state
	line_t nl [WAYS];
	always_comb begin
		for (int i = 0; i < WAYS; i++) begin
			nl[i] = (policy_q == POLICY_SHIP && !hit_q) ? aged[i] : ln[i];
			if (policy_q == POLICY_LRU) begin
				if (ln[i].rank < ln[vic_q].rank) nl[i].rank = ln[i].rank + 1'b1;
				if (WAY_W'(i) == vic_q) nl[i].rank = '0;
			end else if (WAY_W'(i) == vic_q) begin
				if (hit_q) begin
					nl[i].reused = 1'b1;
					nl[i].rrpv = '0;
				end else begin
					nl[i].reused = 1'b0;
					nl[i].sig = nsig_q;
					nl[i].rrpv = ins_zero ? RRPV_MAX : RRPV_LONG;
				end
			end
		end
		for (int i = 0; i < WAYS; i++) row_wdata[i*LINE_W +: LINE_W] = nl[i];
	end

	// counter update values
	logic [CNT_W-1:0] ecnt_new;
	assign ecnt_new = hit_q ? (cnt_rdata == CNT_MAX ? cnt_rdata : cnt_rdata + 1'b1)
		: (cnt_rdata == '0 ? cnt_rdata : cnt_rdata - 1'b1);

	always_comb begin
		row_we = 1'b0;
		row_waddr = set_q;
		cnt_we = 1'b0;
		cnt_waddr = esig_q;
		cnt_wdata = ecnt_new;
		cnt_raddr = esig_q;
		case (st_q)
			ST_CLR: begin
				row_we = (clr_q < CLR_W'(SETS));
				row_waddr = clr_q[SET_W-1:0];
				cnt_we = 1'b1;
				cnt_waddr = clr_q[SIG_W-1:0];
				cnt_wdata = CNT_INIT;
			end
			ST_RD: cnt_raddr = ln[vic_c].sig;
			ST_CNT: begin
				cnt_raddr = nsig_q;
				cnt_we = policy_q == POLICY_SHIP && (hit_q || low_q);
			end
			ST_WR: row_we = 1'b1;
			default: ;
		endcase
	end

	// reset row image during clear
	logic [ROW_W-1:0] rst_row;
	always_comb
		for (int i = 0; i < WAYS; i++)
			rst_row[i*LINE_W +: LINE_W] = {RRPV_MAX, 1'b0, SIG_W'(0), RANK_W'(i)};

	assign wd = (st_q == ST_CLR) ? rst_row : row_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR;
			clr_q <= '0;
			policy_q <= POLICY_SHIP;
			m_tvalid <= 1'b0;
		end else begin
			if (cfg_valid) policy_q <= cfg_data;
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			case (st_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_W'(CNT_ENTRIES-1)) st_q <= ST_IDLE;
				end
				ST_IDLE: if (accept) st_q <= ST_RD;
				// wait here while the previous result is still held
				ST_RD: if (!m_tvalid || m_tready) st_q <= ST_CNT;
				ST_CNT: st_q <= ST_WR;
				ST_WR: begin
					st_q <= ST_IDLE;
					m_tvalid <= 1'b1;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			set_q <= s_tdata[5:0];
			hw_q <= s_tdata[9:6];
			nsig_q <= s_tdata[19:10];
			hit_q <= s_tuser;
		end
		if (st_q == ST_RD) begin
			vic_q <= vic_c;
			esig_q <= ln[vic_c].sig;
			low_q <= !hit_q && policy_q == POLICY_SHIP && !ln[vic_c].reused;
		end
		if (st_q == ST_CNT) ecnt_q <= cnt_rdata;
		if (st_q == ST_WR) begin
			m_tdata <= {1'b0, low_q, hit_q ? SIG_W'(0) : esig_q, vic_q};
			m_tuser <= !hit_q;
		end
	end

	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready) else $error("accepted while busy");
	a_wr_out: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_WR) |=> m_tvalid) else $error("result not raised");
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed while held");
endmodule
`default_nettype wire
